FILE: src/assert_macros.svh
// Assertion helpers shared by the RTL. Each use expands to one labeled
// concurrent assertion that is disabled while reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME_CYCLE(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT_CYCLE(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

FILE: src/nlq_pkg.sv
package nlq_pkg;

    localparam int unsigned NLQ_DEFAULT_SLOTS = 64;

    localparam logic [15:0] EWMA_UNITY       = 16'h0100;
    localparam int unsigned EWMA_ALPHA_SHIFT = 6;
    localparam logic [3:0]  HEADER_VERSION   = 4'h1;

    typedef enum logic [2:0] {
        ST_KNOWN      = 3'd0,
        ST_NEW        = 3'd1,
        ST_BAD_HEADER = 3'd2,
        ST_OWN        = 3'd3,
        ST_FULL       = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_SCAN,
        FSM_DONE
    } fsm_state_t;

    // One neighbor entry as kept in the lookup table.
    typedef struct packed {
        logic [15:0] addr;
        logic [7:0]  last_seq;
        logic [15:0] average;
    } entry_t;

    // Radio figures of the most recent word from a neighbor.
    typedef struct packed {
        logic [15:0] strength;
        logic [15:0] quality;
    } radio_t;

endpackage

FILE: src/neighbor_link_quality_table.sv
// Channel  | Direction | Handshake            | Payload
// input    | in        | in_valid / in_ready  | sender_address, header_byte, sequence_number,
//          |           |                      | signal_strength, link_quality
// output   | out       | out_valid / out_ready| status, slot_index, time_to_live, gap,
//          |           |                      | average_gap, ignored_count
// config   | in        | cfg_wr_en            | cfg_wr_data (own address)
//
// A dropped word skips the table scan; a known sender ends the scan at its slot, and a new
// sender or a full table scans every slot in use. The scan reads and compares one entry
// per cycle through the single read port of the neighbor table. The block takes one word
// at a time.
// Reset (rst_n, asynchronous, active low) empties the table and clears the drop count;
// no clearing pass is needed. A stalled output holds the result, and the block waits
// with in_ready low until it can hand it over.
module neighbor_link_quality_table
    import nlq_pkg::*;
#(
    parameter int unsigned NEIGHBOR_SLOTS = NLQ_DEFAULT_SLOTS
)(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] sender_address,
    input  logic [7:0]  header_byte,
    input  logic [7:0]  sequence_number,
    input  logic [15:0] signal_strength,
    input  logic [15:0] link_quality,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [5:0]  slot_index,
    output logic [3:0]  time_to_live,
    output logic [7:0]  gap,
    output logic [15:0] average_gap,
    output logic [15:0] ignored_count
);

    `include "assert_macros.svh"

    localparam int unsigned CNT_W = $clog2(NEIGHBOR_SLOTS + 1);
    localparam int unsigned IDX_W = (NEIGHBOR_SLOTS > 1) ? $clog2(NEIGHBOR_SLOTS) : 1;

    // Control state
    fsm_state_t         state_reg, state_next;
    logic [CNT_W-1:0]   scan_idx_reg, scan_idx_next;
    logic               cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0]   cmp_idx_reg, cmp_idx_next;
    logic [CNT_W-1:0]   used_reg, used_next;
    logic [15:0]        ignored_reg, ignored_next;
    logic [15:0]        own_reg;
    logic               out_valid_reg;

    // Captured word
    logic [15:0]        sender_reg;
    logic [3:0]         ttl_reg;
    logic [7:0]         seq_reg;
    logic [15:0]        rssi_reg;
    logic [15:0]        lqi_reg;

    // Result waiting for the output register
    status_t            res_status_reg, res_status_next;
    logic [IDX_W-1:0]   res_slot_reg, res_slot_next;
    logic [7:0]         res_gap_reg, res_gap_next;
    logic [15:0]        res_avg_reg, res_avg_next;

    // Output register
    status_t            out_status_reg;
    logic [IDX_W-1:0]   out_slot_reg;
    logic [3:0]         out_ttl_reg;
    logic [7:0]         out_gap_reg;
    logic [15:0]        out_avg_reg;
    logic [15:0]        out_ignored_reg;

    // Table memories
    entry_t             tbl_mem [NEIGHBOR_SLOTS];
    radio_t             radio_mem [NEIGHBOR_SLOTS];
    entry_t             tbl_rdata_reg;
    logic               tbl_we;
    logic [IDX_W-1:0]   tbl_waddr;
    entry_t             tbl_wdata;
    radio_t             radio_wdata;

    logic               in_accept;
    logic               out_load;
    logic               hdr_bad;
    logic               hit;
    logic [7:0]         upd_gap;
    logic [17:0]        avg_times3;
    logic [15:0]        upd_avg;

    assign in_ready  = (state_reg == FSM_IDLE);
    assign in_accept = in_valid && in_ready;
    assign hdr_bad   = (header_byte[7:4] != HEADER_VERSION) || (header_byte[3:0] == 4'h0);

    // The shared comparator checks one table entry per cycle against the sender.
    assign hit = cmp_valid_reg && (tbl_rdata_reg.addr == sender_reg);

    // EWMA: gap * 64 + floor(avg * 3 / 4).
    assign upd_gap    = seq_reg - tbl_rdata_reg.last_seq;
    assign avg_times3 = {2'b00, tbl_rdata_reg.average} + {1'b0, tbl_rdata_reg.average, 1'b0};
    assign upd_avg    = ({8'h00, upd_gap} << EWMA_ALPHA_SHIFT) + avg_times3[17:2];

    always_comb
    begin
        state_next      = state_reg;
        scan_idx_next   = scan_idx_reg;
        cmp_valid_next  = 1'b0;
        cmp_idx_next    = cmp_idx_reg;
        used_next       = used_reg;
        ignored_next    = ignored_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_gap_next    = res_gap_reg;
        res_avg_next    = res_avg_reg;
        tbl_we          = 1'b0;
        tbl_waddr       = cmp_idx_reg;
        tbl_wdata       = '{addr: sender_reg, last_seq: seq_reg, average: upd_avg};
        radio_wdata     = '{strength: rssi_reg, quality: lqi_reg};
        out_load        = 1'b0;

        case (state_reg)
            FSM_IDLE:
            begin
                if (in_valid)
                begin
                    scan_idx_next = '0;
                    res_slot_next = '0;
                    res_gap_next  = '0;
                    res_avg_next  = '0;
                    if (hdr_bad)
                    begin
                        res_status_next = ST_BAD_HEADER;
                        ignored_next    = ignored_reg + 16'd1;
                        state_next      = FSM_DONE;
                    end
                    else if (sender_address == own_reg)
                    begin
                        res_status_next = ST_OWN;
                        ignored_next    = ignored_reg + 16'd1;
                        state_next      = FSM_DONE;
                    end
                    else
                    begin
                        state_next = FSM_SCAN;
                    end
                end
            end

            FSM_SCAN:
            begin
                if (hit)
                begin
                    tbl_we          = 1'b1;
                    tbl_waddr       = cmp_idx_reg;
                    res_status_next = ST_KNOWN;
                    res_slot_next   = cmp_idx_reg;
                    res_gap_next    = upd_gap;
                    res_avg_next    = upd_avg;
                    state_next      = FSM_DONE;
                end
                else if (scan_idx_reg == used_reg)
                begin
                    if (used_reg == CNT_W'(NEIGHBOR_SLOTS))
                    begin
                        res_status_next = ST_FULL;
                    end
                    else
                    begin
                        // A new sender starts at gap 1 and average 1.0, which the
                        // update leaves at 1.0.
                        tbl_we          = 1'b1;
                        tbl_waddr       = used_reg[IDX_W-1:0];
                        tbl_wdata       = '{addr: sender_reg, last_seq: seq_reg,
                                            average: EWMA_UNITY};
                        used_next       = used_reg + 1'b1;
                        res_status_next = ST_NEW;
                        res_slot_next   = used_reg[IDX_W-1:0];
                        res_gap_next    = 8'd1;
                        res_avg_next    = EWMA_UNITY;
                    end
                    state_next = FSM_DONE;
                end
                else
                begin
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = scan_idx_reg[IDX_W-1:0];
                    scan_idx_next  = scan_idx_reg + 1'b1;
                end
            end

            FSM_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = FSM_IDLE;
                end
            end

            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= FSM_IDLE;
            scan_idx_reg  <= '0;
            cmp_valid_reg <= 1'b0;
            used_reg      <= '0;
            ignored_reg   <= '0;
            own_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_idx_reg  <= scan_idx_next;
            cmp_valid_reg <= cmp_valid_next;
            used_reg      <= used_next;
            ignored_reg   <= ignored_next;
            if (cfg_wr_en)
            begin
                own_reg <= cfg_wr_data;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg    <= cmp_idx_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_gap_reg    <= res_gap_next;
        res_avg_reg    <= res_avg_next;
        if (in_accept)
        begin
            sender_reg <= sender_address;
            ttl_reg    <= header_byte[3:0];
            seq_reg    <= sequence_number;
            rssi_reg   <= signal_strength;
            lqi_reg    <= link_quality;
        end
        if (out_load)
        begin
            out_status_reg  <= res_status_reg;
            out_slot_reg    <= res_slot_reg;
            out_ttl_reg     <= ttl_reg;
            out_gap_reg     <= res_gap_reg;
            out_avg_reg     <= res_avg_reg;
            out_ignored_reg <= ignored_reg;
        end
    end

    // Neighbor table: one write port, one registered read port driven by the scan.
    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            tbl_mem[tbl_waddr]   <= tbl_wdata;
            radio_mem[tbl_waddr] <= radio_wdata;
        end
        tbl_rdata_reg <= tbl_mem[scan_idx_reg[IDX_W-1:0]];
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign slot_index    = 6'(out_slot_reg);
    assign time_to_live  = out_ttl_reg;
    assign gap           = out_gap_reg;
    assign average_gap   = out_avg_reg;
    assign ignored_count = out_ignored_reg;

    `ASSERT_SAME_CYCLE(a_used_bound, clk, rst_n, 1'b1, used_reg <= CNT_W'(NEIGHBOR_SLOTS))
    `ASSERT_SAME_CYCLE(a_cmp_in_range, clk, rst_n, cmp_valid_reg, CNT_W'(cmp_idx_reg) < used_reg)
    `ASSERT_NEXT_CYCLE(a_accept_leaves_idle, clk, rst_n, in_accept, state_reg != FSM_IDLE)
    `ASSERT_NEXT_CYCLE(a_new_slot_counted, clk, rst_n,
                       (state_reg == FSM_SCAN) && tbl_we && !hit,
                       used_reg == $past(used_reg) + 1'b1)

endmodule

FILE: verif/link_table_checker.sv
`timescale 1ns / 100ps

// Watches both channels and the address register port of the neighbor table,
// predicts each result word from the header words it sees accepted, and
// compares results field by field in order.
module link_table_checker
    import nlq_pkg::*;
#(
    parameter int unsigned NEIGHBOR_SLOTS = NLQ_DEFAULT_SLOTS
)(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,

    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [15:0] sender_address,
    input  logic [7:0]  header_byte,
    input  logic [7:0]  sequence_number,
    input  logic [15:0] signal_strength,
    input  logic [15:0] link_quality,

    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [2:0]  status,
    input  logic [5:0]  slot_index,
    input  logic [3:0]  time_to_live,
    input  logic [7:0]  gap,
    input  logic [15:0] average_gap,
    input  logic [15:0] ignored_count,

    output int          fail_count,
    output int          outstanding,
    output int          results_checked,
    output int          drops_seen,
    output int          full_seen
);

    typedef struct {
        status_t     status;
        logic [5:0]  slot;
        logic [3:0]  ttl;
        logic [7:0]  gap;
        logic [15:0] average;
        logic [15:0] ignored;
    } link_report_t;

    logic [15:0]  my_address;
    logic [15:0]  nb_addr [NEIGHBOR_SLOTS];
    logic [7:0]   nb_seq [NEIGHBOR_SLOTS];
    logic [15:0]  nb_avg [NEIGHBOR_SLOTS];
    int unsigned  nb_used;
    logic [15:0]  drop_total;
    link_report_t expected_reports [$];

    // Radio figures are stored by the block but never reported, so they are
    // not tracked here.
    function automatic link_report_t table_lookup_update(input logic [15:0] sender,
                                                         input logic [7:0]  head,
                                                         input logic [7:0]  seq);
        link_report_t rep;
        int           slot;
        logic [7:0]   step_gap;
        logic [31:0]  blended;
        rep.status  = ST_KNOWN;
        rep.slot    = '0;
        rep.ttl     = head[3:0];
        rep.gap     = '0;
        rep.average = '0;
        slot        = -1;
        // The header check wins over the own-address check.
        if (head[7:4] != HEADER_VERSION || head[3:0] == 4'h0) begin
            drop_total  = drop_total + 16'd1;
            rep.status  = ST_BAD_HEADER;
            rep.ignored = drop_total;
            return rep;
        end
        if (sender == my_address) begin
            drop_total  = drop_total + 16'd1;
            rep.status  = ST_OWN;
            rep.ignored = drop_total;
            return rep;
        end
        for (int i = 0; i < int'(nb_used); i++) begin
            if (slot < 0 && nb_addr[i] == sender)
                slot = i;
        end
        if (slot < 0) begin
            // A full table answers without touching the drop counter.
            if (nb_used >= NEIGHBOR_SLOTS) begin
                rep.status  = ST_FULL;
                rep.ignored = drop_total;
                return rep;
            end
            slot          = nb_used;
            nb_used       = nb_used + 1;
            nb_addr[slot] = sender;
            nb_seq[slot]  = seq - 8'd1;
            nb_avg[slot]  = EWMA_UNITY;
            rep.status    = ST_NEW;
        end
        step_gap = seq - nb_seq[slot];
        blended  = (32'(step_gap) << EWMA_ALPHA_SHIFT)
                 + (32'(nb_avg[slot]) * (32'(EWMA_UNITY) - (32'd1 << EWMA_ALPHA_SHIFT)))
                   / 32'(EWMA_UNITY);
        nb_avg[slot] = blended[15:0];
        nb_seq[slot] = seq;
        rep.slot     = 6'(slot);
        rep.gap      = step_gap;
        rep.average  = blended[15:0];
        rep.ignored  = drop_total;
        return rep;
    endfunction

    task automatic check_field(input string field, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
            fail_count = fail_count + 1;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        link_report_t want;
        if (!rst_n) begin
            my_address = 16'h0000;
            nb_used    = 0;
            drop_total = 16'h0000;
            expected_reports.delete();
            fail_count      = 0;
            results_checked = 0;
            drops_seen      = 0;
            full_seen       = 0;
            outstanding    <= 0;
        end else begin
            if (cfg_wr_en)
                my_address = cfg_wr_data;
            if (out_valid && out_ready) begin
                results_checked = results_checked + 1;
                if (expected_reports.size() == 0) begin
                    $error("result word with nothing expected: status 0x%0h", status);
                    fail_count = fail_count + 1;
                end else begin
                    want = expected_reports.pop_front();
                    check_field("status", 16'(want.status), 16'(status));
                    check_field("slot_index", 16'(want.slot), 16'(slot_index));
                    check_field("time_to_live", 16'(want.ttl), 16'(time_to_live));
                    check_field("gap", 16'(want.gap), 16'(gap));
                    check_field("average_gap", want.average, average_gap);
                    check_field("ignored_count", want.ignored, ignored_count);
                    if (want.status == ST_BAD_HEADER || want.status == ST_OWN)
                        drops_seen = drops_seen + 1;
                    if (want.status == ST_FULL)
                        full_seen = full_seen + 1;
                end
            end
            if (in_valid && in_ready)
                expected_reports.push_back(table_lookup_update(sender_address, header_byte,
                                                               sequence_number));
            outstanding <= expected_reports.size();
        end
    end

endmodule

FILE: verif/neighbor_link_quality_table_tb.sv
`timescale 1ns / 100ps

module neighbor_link_quality_table_tb;
    import nlq_pkg::*;

    localparam int unsigned SLOTS = NLQ_DEFAULT_SLOTS;
    localparam int POOL_SIZE       = 80;
    localparam int RANDOM_PHASES   = 5;
    localparam int WORDS_PER_PHASE = 246;

    logic        clk             = 1'b0;
    logic        rst_n           = 1'b0;
    logic        cfg_wr_en       = 1'b0;
    logic [15:0] cfg_wr_data     = 16'h0000;
    logic        in_valid        = 1'b0;
    logic [15:0] sender_address  = 16'h0000;
    logic [7:0]  header_byte     = 8'h00;
    logic [7:0]  sequence_number = 8'h00;
    logic [15:0] signal_strength = 16'h0000;
    logic [15:0] link_quality    = 16'h0000;
    logic        out_ready       = 1'b0;

    logic        in_ready;
    logic        out_valid;
    logic [2:0]  status;
    logic [5:0]  slot_index;
    logic [3:0]  time_to_live;
    logic [7:0]  gap;
    logic [15:0] average_gap;
    logic [15:0] ignored_count;

    int fail_count;
    int outstanding;
    int results_checked;
    int drops_seen;
    int full_seen;

    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          words_sent     = 0;
    int          address_writes = 0;
    logic [15:0] own_now        = 16'h0000;
    logic [15:0] pool [POOL_SIZE];
    logic [7:0]  pool_seq [POOL_SIZE];

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);

    neighbor_link_quality_table #(
        .NEIGHBOR_SLOTS (SLOTS)
    ) dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .sender_address  (sender_address),
        .header_byte     (header_byte),
        .sequence_number (sequence_number),
        .signal_strength (signal_strength),
        .link_quality    (link_quality),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .slot_index      (slot_index),
        .time_to_live    (time_to_live),
        .gap             (gap),
        .average_gap     (average_gap),
        .ignored_count   (ignored_count)
    );

    link_table_checker #(
        .NEIGHBOR_SLOTS (SLOTS)
    ) scoreboard (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .sender_address  (sender_address),
        .header_byte     (header_byte),
        .sequence_number (sequence_number),
        .signal_strength (signal_strength),
        .link_quality    (link_quality),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .slot_index      (slot_index),
        .time_to_live    (time_to_live),
        .gap             (gap),
        .average_gap     (average_gap),
        .ignored_count   (ignored_count),
        .fail_count      (fail_count),
        .outstanding     (outstanding),
        .results_checked (results_checked),
        .drops_seen      (drops_seen),
        .full_seen       (full_seen)
    );

    // Returns at the edge where the word is taken, with valid still high.
    task automatic send_word(input logic [15:0] addr, input logic [7:0] head,
                             input logic [7:0] seq, input logic [15:0] rssi,
                             input logic [15:0] lqi);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid        <= 1'b1;
        sender_address  <= addr;
        header_byte     <= head;
        sequence_number <= seq;
        signal_strength <= rssi;
        link_quality    <= lqi;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        words_sent++;
    endtask

    // The checker's count is registered and lags the queue, so look at it only once it has been updated.
    task automatic drain_results;
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic write_own_address(input logic [15:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        own_now      = value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        address_writes++;
    endtask

    // Mostly neighbors from a fixed pool counting up their sequence numbers,
    // with stray senders, our own address and broken headers mixed in.
    task automatic send_random_word;
        int          pick;
        int          idx;
        logic [15:0] addr;
        logic [7:0]  head;
        logic [7:0]  seq;
        pick = $urandom_range(0, 99);
        idx  = $urandom_range(0, POOL_SIZE - 1);
        seq  = 8'($urandom);
        if (pick < 5) begin
            addr = own_now;
        end else if (pick < 15) begin
            addr = 16'($urandom);
        end else begin
            addr = pool[idx];
            pick = $urandom_range(0, 99);
            if (pick < 75)
                seq = pool_seq[idx] + 8'd1;
            else if (pick < 85)
                seq = pool_seq[idx] + 8'($urandom_range(2, 5));
            else if (pick < 90)
                seq = pool_seq[idx];
            pool_seq[idx] = seq;
        end
        if ($urandom_range(0, 99) < 85)
            head = {HEADER_VERSION, 4'($urandom_range(1, 15))};
        else
            head = 8'($urandom);
        send_word(addr, head, seq, 16'($urandom), 16'($urandom));
    endtask

    initial begin
        for (int i = 0; i < POOL_SIZE; i++) begin
            pool[i]     = {9'($urandom), 7'(i)};
            pool_seq[i] = 8'($urandom);
        end
        pool[0] = 16'h0000;
        pool[1] = 16'hFFFF;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_own_address(16'hABCD);
        send_word(pool[2], 8'h00, 8'h00, 16'h0000, 16'h0000);
        send_word(pool[2], 8'h10, 8'h01, 16'h0000, 16'h0000);
        send_word(pool[2], 8'hF5, 8'h02, 16'hFFFF, 16'hFFFF);
        send_word(pool[2], 8'h2F, 8'h03, 16'h1234, 16'h4321);
        send_word(16'hABCD, 8'h11, 8'h04, 16'h0000, 16'h0000);
        // Broken header from our own address counts as a bad header.
        send_word(16'hABCD, 8'h00, 8'h05, 16'h0000, 16'h0000);
        send_word(16'h0000, 8'h1F, 8'h00, 16'h0000, 16'hFFFF);
        send_word(16'h0000, 8'h11, 8'h00, 16'hFFFF, 16'h0000);
        send_word(16'h0000, 8'h18, 8'hFF, 16'h8000, 16'h0001);
        send_word(16'h0000, 8'h18, 8'h00, 16'h0001, 16'h8000);
        send_word(16'hFFFF, 8'h1F, 8'hFF, 16'hFFFF, 16'hFFFF);
        // A sender running backwards pushes its average toward the top.
        for (int k = 0; k < 8; k++)
            send_word(16'hFFFF, 8'h11, 8'hFE - 8'(k), 16'hFFFF, 16'h0000);
        send_word(pool[2], 8'h1A, 8'h80, 16'h5555, 16'hAAAA);
        drain_results;

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    write_own_address(16'h0000);
                end
                1: begin
                    send_idle_pct  = 73;
                    recv_stall_pct = 0;
                    write_own_address(16'hFFFF);
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 73;
                    write_own_address(pool[$urandom_range(2, POOL_SIZE - 1)]);
                end
                3: begin
                    send_idle_pct  = 25;
                    recv_stall_pct = 25;
                    write_own_address(16'($urandom));
                end
                default: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    write_own_address(16'($urandom));
                end
            endcase
            repeat (WORDS_PER_PHASE)
                send_random_word();
            drain_results;
        end

        repeat (SLOTS + 8) @(posedge clk);
        $display("Sent %0d header words under %0d own-address settings and four pacing modes.",
                 words_sent, address_writes);
        $display("Checked %0d results: %0d dropped headers, %0d table-full answers.",
                 results_checked, drops_seen, full_seen);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
